>>> rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and helpers for the fixed-point unit
// Opcodes, channel structs, the pipeline item carried along the cell chain
// and the saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int DATA_W        = 32;
	localparam int ACC_W         = 64;
	// one quotient bit per divider cell
	localparam int Q_BITS        = DATA_W + FRACTION_BITS;
	// start edge to the edge that takes the result
	localparam int PIPE_LAT      = Q_BITS + 2;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_CMP      = 4'd4,
		CMD_INC      = 4'd5,
		CMD_DEC      = 4'd6,
		CMD_FROM_INT = 4'd7,
		CMD_TO_INT   = 4'd8,
		CMD_MAX      = 4'd9
	} cmd_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_raw;
		logic               greater;
		logic               greater_equal;
		logic               less;
		logic               less_equal;
		logic               not_equal;
		logic               div_by_zero;
		logic               overflow;
	} rsp_t;

	typedef struct packed {
		logic       gt;
		logic       ge;
		logic       lt;
		logic       le;
		logic       ne;
	} cmp_t;

	typedef struct packed {
		logic [3:0]        cmd;
		logic              neg;
		logic              dz;
		logic              ovf;
		logic [DATA_W-1:0] res;
		cmp_t              cmp;
		logic [DATA_W-1:0] dvs;
		logic [DATA_W-1:0] rem;
		logic [ACC_W-1:0]  acc;
	} item_t;

	// {overflow, value}: sign and magnitude packed into 32 bits, saturating
	function automatic logic [DATA_W:0] sat_pack(input logic neg, input logic [ACC_W-1:0] mag);
		logic [DATA_W:0] r;
		if (!neg) begin
			if (mag > ACC_W'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag[DATA_W-1:0]};
		end else begin
			if (mag > ACC_W'(32'h8000_0000)) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, 32'(-mag[DATA_W-1:0])};
		end
		return r;
	endfunction

	// {overflow, value} from a 33-bit signed sum
	function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] s);
		logic [DATA_W:0] r;
		if (s[DATA_W] != s[DATA_W-1])
			r = {1'b1, s[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF};
		else
			r = {1'b0, s[DATA_W-1:0]};
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: signed 32-bit fixed-point arithmetic unit
// Add, subtract, multiply, divide, compare, max and conversions on raw
// fixed-point words, saturating, one transaction per cycle.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start, busy        req  (cmd, operand_a, operand_b)
//  result    done (strobe)      rsp  (result_raw, flags)
//
//  A transaction is taken at every edge with start high; busy stays low.
//  Every opcode passes the input register, the divider chain and the
//  result register; the chain has one cell per quotient bit.
//  Results leave in order, one cycle each, and cannot be held off.
//  Reset clears the valid bits of the pipeline; payload is not reset.
`default_nettype none
module fixed_point_alu (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	input  wire fpa_pkg::req_t req,
	output      logic          done,
	output      fpa_pkg::rsp_t rsp
);

	logic                     valid_s1;
	fpa_pkg::item_t           item_s1;
	fpa_pkg::item_t           fr;
	logic [fpa_pkg::DATA_W-1:0] mag_a;
	logic [fpa_pkg::DATA_W-1:0] mag_b;
	logic [fpa_pkg::DATA_W:0]   tmp;
	logic [fpa_pkg::ACC_W-1:0]  shl;

	logic           cv [0:fpa_pkg::Q_BITS];
	fpa_pkg::item_t ci [0:fpa_pkg::Q_BITS];

	assign busy = 1'b0;

	always_comb begin
		mag_a = req.operand_a[31] ? 32'(-req.operand_a) : 32'(req.operand_a);
		mag_b = req.operand_b[31] ? 32'(-req.operand_b) : 32'(req.operand_b);
		shl   = {32'b0, mag_a} << fpa_pkg::FRACTION_BITS;
		tmp   = '0;
		fr.cmd    = req.cmd;
		fr.neg    = req.operand_a[31] ^ req.operand_b[31];
		fr.dz     = 1'b0;
		fr.ovf    = 1'b0;
		fr.res    = '0;
		fr.dvs    = mag_b;
		fr.rem    = '0;
		fr.acc    = '0;
		fr.cmp.gt = req.operand_a >  req.operand_b;
		fr.cmp.ge = req.operand_a >= req.operand_b;
		fr.cmp.lt = req.operand_a <  req.operand_b;
		fr.cmp.le = req.operand_a <= req.operand_b;
		fr.cmp.ne = req.operand_a != req.operand_b;
		case (req.cmd)
			fpa_pkg::CMD_ADD: tmp = fpa_pkg::sat_sum({req.operand_a[31], req.operand_a}
			                                         + {req.operand_b[31], req.operand_b});
			fpa_pkg::CMD_SUB: tmp = fpa_pkg::sat_sum({req.operand_a[31], req.operand_a}
			                                         - {req.operand_b[31], req.operand_b});
			fpa_pkg::CMD_INC: tmp = fpa_pkg::sat_sum({req.operand_a[31], req.operand_a} + 33'd1);
			fpa_pkg::CMD_DEC: tmp = fpa_pkg::sat_sum({req.operand_a[31], req.operand_a} - 33'd1);
			fpa_pkg::CMD_MUL: fr.acc = {32'b0, mag_a} * {32'b0, mag_b};
			fpa_pkg::CMD_DIV: begin
				fr.acc = shl;
				fr.dz  = (req.operand_b == '0);
			end
			fpa_pkg::CMD_FROM_INT: tmp = fpa_pkg::sat_pack(req.operand_a[31], shl);
			fpa_pkg::CMD_TO_INT:
				tmp = {1'b0, 32'(req.operand_a >>> fpa_pkg::FRACTION_BITS)};
			fpa_pkg::CMD_MAX:
				tmp = {1'b0, fr.cmp.gt ? req.operand_a : req.operand_b};
			default: tmp = '0;
		endcase
		fr.res = tmp[fpa_pkg::DATA_W-1:0];
		fr.ovf = tmp[fpa_pkg::DATA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= fr;
	end

	assign cv[0] = valid_s1;
	assign ci[0] = item_s1;

	for (genvar i = 0; i < fpa_pkg::Q_BITS; i++) begin : g_cell
		fpa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[i]),
			.in_item  (ci[i]),
			.out_valid(cv[i+1]),
			.out_item (ci[i+1])
		);
	end

	fpa_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cv[fpa_pkg::Q_BITS]),
		.in_item (ci[fpa_pkg::Q_BITS]),
		.done    (done),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

>>> rtl/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell: one divider cell of the chain
// For a divide, resolves one quotient bit by restoring subtraction; every
// transaction passes on to the next cell every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire fpa_pkg::item_t in_item,
	output      logic          out_valid,
	output      fpa_pkg::item_t out_item
);

	logic                     valid_q;
	fpa_pkg::item_t           item_q;
	fpa_pkg::item_t           nxt;
	logic [fpa_pkg::DATA_W:0] part;
	logic [fpa_pkg::DATA_W:0] diff;

	always_comb begin
		nxt  = in_item;
		part = {in_item.rem, in_item.acc[fpa_pkg::Q_BITS-1]};
		diff = part - {1'b0, in_item.dvs};
		if (in_item.cmd == fpa_pkg::CMD_DIV) begin
			// shift numerator left, take quotient bit into the low end
			nxt.rem = diff[fpa_pkg::DATA_W] ? part[fpa_pkg::DATA_W-1:0]
			                                : diff[fpa_pkg::DATA_W-1:0];
			nxt.acc = {in_item.acc[fpa_pkg::ACC_W-2:0], ~diff[fpa_pkg::DATA_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
`default_nettype wire

>>> rtl/fpa_finish.sv
// ----------------------------------------------------------------------------
// fpa_finish: rounding, saturation and result register
// Rounds the product and quotient half away from zero, saturates and
// drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_finish (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire fpa_pkg::item_t in_item,
	output      logic           done,
	output      fpa_pkg::rsp_t  rsp
);

	logic                     done_q;
	fpa_pkg::rsp_t            rsp_q;
	fpa_pkg::rsp_t            nxt;
	logic [fpa_pkg::ACC_W-1:0] mq;
	logic [fpa_pkg::ACC_W-1:0] dq;
	logic                     rnd;
	logic [fpa_pkg::DATA_W:0] pk;

	always_comb begin
		mq  = (in_item.acc + (fpa_pkg::ACC_W'(1) << (fpa_pkg::FRACTION_BITS - 1)))
		      >> fpa_pkg::FRACTION_BITS;
		// round up when twice the remainder reaches the divisor
		rnd = {in_item.rem, 1'b0} >= {1'b0, in_item.dvs};
		dq  = {{(fpa_pkg::ACC_W-fpa_pkg::Q_BITS){1'b0}}, in_item.acc[fpa_pkg::Q_BITS-1:0]}
		      + fpa_pkg::ACC_W'(rnd);
		pk  = '0;
		nxt.result_raw    = in_item.res;
		nxt.overflow      = in_item.ovf;
		nxt.div_by_zero   = in_item.dz;
		nxt.greater       = in_item.cmp.gt;
		nxt.greater_equal = in_item.cmp.ge;
		nxt.less          = in_item.cmp.lt;
		nxt.less_equal    = in_item.cmp.le;
		nxt.not_equal     = in_item.cmp.ne;
		case (in_item.cmd)
			fpa_pkg::CMD_MUL: begin
				pk = fpa_pkg::sat_pack(in_item.neg && (mq != '0), mq);
				nxt.result_raw = pk[fpa_pkg::DATA_W-1:0];
				nxt.overflow   = pk[fpa_pkg::DATA_W];
			end
			fpa_pkg::CMD_DIV: begin
				if (!in_item.dz) begin
					pk = fpa_pkg::sat_pack(in_item.neg && (dq != '0), dq);
					nxt.result_raw = pk[fpa_pkg::DATA_W-1:0];
					nxt.overflow   = pk[fpa_pkg::DATA_W];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= nxt;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

>>> rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker: port-level checks for the fixed-point unit
// Fixed latency, flag consistency and bind to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire fpa_pkg::req_t req,
	input wire logic          done,
	input wire fpa_pkg::rsp_t rsp
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(fpa_pkg::PIPE_LAT) done)
		else $error("transaction result missing at fixed latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start && !busy, fpa_pkg::PIPE_LAT) |-> !done)
		else $error("result without transaction");

	a_order_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.greater_equal == !rsp.less) && (rsp.less_equal == !rsp.greater)
		         && (rsp.not_equal == (rsp.greater || rsp.less)))
		else $error("inconsistent comparison flags");

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.div_by_zero |-> !rsp.overflow && (rsp.result_raw == '0))
		else $error("divide by zero result not cleared");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);
`default_nettype wire
